// ----- rtl/oai_pkg.sv -----
`timescale 1ns / 1ps

package oai_pkg;

   // default number of elements the store can hold
   localparam int OAI_CAPACITY = 64;

   // fixed field widths of the request and result beats
   localparam int KIND_W     = 3;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 6;
   localparam int LENGTH_W   = 7;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NOT_LOADED   = 2'd1,
      STATUS_BAD_POSITION = 2'd2,
      STATUS_FULL         = 2'd3
   } status_type;

endpackage

// ----- rtl/ordered_array_insert_delete.sv -----
`timescale 1ns / 1ps

// Ordered array store of up to CAPACITY signed 32-bit elements with clear, append, dump,
// insert, update and delete requests. A request is taken when start is high and busy is
// low; each result beat is on the rsp_ ports for exactly one cycle with rsp_strobe high
// and cannot be held off by the receiver, so it must be taken as it comes. Results are
// registered and appear in the cycle after the work that makes them. Clear, append,
// update, unknown kinds, an empty dump and every rejected request are handled from
// idle and busy never rises. Insert, delete and a non-empty dump raise busy after the
// accepting edge, and a dump gives one beat per element in consecutive cycles. Each
// cycle of a shift moves one element through the single element RAM, reading one
// address and writing the previous read back one place over.
module ordered_array_insert_delete #(
   parameter int CAPACITY = oai_pkg::OAI_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [oai_pkg::KIND_W-1:0]          req_kind,
   input  logic [oai_pkg::POSITION_W-1:0]      req_position,
   input  logic signed [oai_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic [oai_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_has_data,
   output logic [oai_pkg::INDEX_W-1:0]         rsp_element_index,
   output logic signed [oai_pkg::VALUE_W-1:0]  rsp_element_value,
   output logic [oai_pkg::LENGTH_W-1:0]        rsp_new_length,
   output logic                                rsp_last
);

   import oai_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = (LW > POSITION_W) ? LW : POSITION_W;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_PUT,
      S_DOWN,
      S_DUMP
   } state_type;

   state_type             state_ff;
   logic                  loaded_ff;
   logic [LW-1:0]         len_ff;
   logic [LW-1:0]         ptr_ff;
   logic [LW-1:0]         pos_ff;
   logic [VALUE_W-1:0]    val_ff;
   logic                  pend_ff;
   logic [AW-1:0]         wadr_ff;

   logic                  rsp_strobe_ff;
   status_type            rsp_status_ff;
   logic                  rsp_has_data_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [LENGTH_W-1:0]   rsp_length_ff;
   logic                  rsp_last_ff;

   logic                  take;
   logic [CW-1:0]         pos_ext;
   logic [CW-1:0]         len_ext;
   logic [LW-1:0]         len_inc;
   logic [LW-1:0]         len_dec;
   logic [LW-1:0]         ptr_inc;
   logic [LW-1:0]         ptr_dec;
   logic [CW-1:0]         len_w;
   logic [CW-1:0]         len_inc_w;
   logic [CW-1:0]         len_dec_w;
   logic [CW-1:0]         idx_w;
   logic [AW-1:0]         wadr_inc;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [VALUE_W-1:0]    ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [VALUE_W-1:0]    ram_rd_data;

   assign take      = start && !busy;
   assign pos_ext   = CW'(req_position);
   assign len_ext   = CW'(len_ff);
   assign len_inc   = len_ff + LW'(1);
   assign len_dec   = len_ff - LW'(1);
   assign ptr_inc   = ptr_ff + LW'(1);
   assign ptr_dec   = ptr_ff - LW'(1);
   assign len_w     = CW'(len_ff);
   assign len_inc_w = CW'(len_inc);
   assign len_dec_w = CW'(len_dec);
   assign idx_w     = CW'(wadr_ff);
   assign wadr_inc  = wadr_ff + AW'(1);

   // element store
   oai_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // ram port steering: direct writes from idle, moved elements during shifts, the new value on insert
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wadr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = ptr_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (take && loaded_ff) begin
               if (req_kind == KIND_APPEND && len_ext < CAP_W) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = len_ff[AW-1:0];
                  ram_wr_data = req_value;
               end else if (req_kind == KIND_UPDATE && pos_ext < len_ext) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = req_position[AW-1:0];
                  ram_wr_data = req_value;
               end
            end
         end
         S_UP: begin
            ram_wr_en   = pend_ff;
            ram_rd_addr = ptr_dec[AW-1:0];
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = val_ff;
         end
         S_DOWN: begin
            ram_wr_en   = pend_ff;
            ram_rd_addr = ptr_inc[AW-1:0];
         end
         S_DUMP: begin
            ram_rd_addr = ptr_ff[AW-1:0];
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // sequencer, store state and result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         loaded_ff     <= 1'b0;
         len_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_status_ff   <= STATUS_OK;
                  rsp_has_data_ff <= 1'b0;
                  rsp_index_ff    <= '0;
                  rsp_value_ff    <= '0;
                  rsp_length_ff   <= len_w[LENGTH_W-1:0];
                  rsp_last_ff     <= 1'b1;
                  pend_ff         <= 1'b0;
                  pos_ff          <= pos_ext[LW-1:0];
                  val_ff          <= req_value;
                  case (req_kind)
                     KIND_CLEAR: begin
                        loaded_ff     <= 1'b1;
                        len_ff        <= '0;
                        rsp_length_ff <= '0;
                     end
                     KIND_APPEND, KIND_DUMP, KIND_INSERT, KIND_UPDATE, KIND_DELETE: begin
                        if (!loaded_ff) begin
                           rsp_status_ff <= STATUS_NOT_LOADED;
                        end else begin
                           case (req_kind)
                              KIND_APPEND: begin
                                 if (len_ext >= CAP_W) begin
                                    rsp_status_ff <= STATUS_FULL;
                                 end else begin
                                    len_ff        <= len_inc;
                                    rsp_length_ff <= len_inc_w[LENGTH_W-1:0];
                                 end
                              end
                              KIND_DUMP: begin
                                 if (len_ff != '0) begin
                                    rsp_strobe_ff <= 1'b0;
                                    ptr_ff        <= '0;
                                    state_ff      <= S_DUMP;
                                 end
                              end
                              KIND_INSERT: begin
                                 if (pos_ext > len_ext) begin
                                    rsp_status_ff <= STATUS_BAD_POSITION;
                                 end else if (len_ext >= CAP_W) begin
                                    rsp_status_ff <= STATUS_FULL;
                                 end else begin
                                    rsp_strobe_ff <= 1'b0;
                                    ptr_ff        <= len_ff;
                                    state_ff      <= S_UP;
                                 end
                              end
                              KIND_UPDATE: begin
                                 if (pos_ext >= len_ext) begin
                                    rsp_status_ff <= STATUS_BAD_POSITION;
                                 end
                              end
                              default: begin
                                 if (pos_ext >= len_ext) begin
                                    rsp_status_ff <= STATUS_BAD_POSITION;
                                 end else begin
                                    rsp_strobe_ff <= 1'b0;
                                    ptr_ff        <= pos_ext[LW-1:0];
                                    state_ff      <= S_DOWN;
                                 end
                              end
                           endcase
                        end
                     end
                     default: begin
                        rsp_status_ff <= STATUS_OK;
                     end
                  endcase
               end
            end
            // move tail up one place, highest element first
            S_UP: begin
               if (ptr_ff > pos_ff) begin
                  pend_ff <= 1'b1;
                  wadr_ff <= ptr_ff[AW-1:0];
                  ptr_ff  <= ptr_dec;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_PUT;
               end
            end
            // drop the new value into the gap
            S_PUT: begin
               len_ff          <= len_inc;
               rsp_strobe_ff   <= 1'b1;
               rsp_status_ff   <= STATUS_OK;
               rsp_has_data_ff <= 1'b0;
               rsp_index_ff    <= '0;
               rsp_value_ff    <= '0;
               rsp_length_ff   <= len_inc_w[LENGTH_W-1:0];
               rsp_last_ff     <= 1'b1;
               state_ff        <= S_IDLE;
            end
            // move tail down one place, lowest element first
            S_DOWN: begin
               if (ptr_inc < len_ff) begin
                  pend_ff <= 1'b1;
                  wadr_ff <= ptr_ff[AW-1:0];
                  ptr_ff  <= ptr_inc;
               end else begin
                  pend_ff         <= 1'b0;
                  len_ff          <= len_dec;
                  rsp_strobe_ff   <= 1'b1;
                  rsp_status_ff   <= STATUS_OK;
                  rsp_has_data_ff <= 1'b0;
                  rsp_index_ff    <= '0;
                  rsp_value_ff    <= '0;
                  rsp_length_ff   <= len_dec_w[LENGTH_W-1:0];
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= S_IDLE;
               end
            end
            // stream every element out, one beat per cycle
            S_DUMP: begin
               if (pend_ff) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_status_ff   <= STATUS_OK;
                  rsp_has_data_ff <= 1'b1;
                  rsp_index_ff    <= idx_w[INDEX_W-1:0];
                  rsp_value_ff    <= ram_rd_data;
                  rsp_length_ff   <= len_w[LENGTH_W-1:0];
                  rsp_last_ff     <= (CW'(wadr_inc) == len_w) || (ptr_ff == len_ff);
               end
               if (ptr_ff < len_ff) begin
                  pend_ff <= 1'b1;
                  wadr_ff <= ptr_ff[AW-1:0];
                  ptr_ff  <= ptr_inc;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_has_data      = rsp_has_data_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_new_length    = rsp_length_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- rtl/oai_ram.sv -----
`timescale 1ns / 1ps

module oai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
